@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each use checks on the rising clock edge
// and stays quiet while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

`endif

@@ sv/thnq_pkg.sv @@
package thnq_pkg;

  // Width of the vertex limit register.
  localparam int unsigned LimW = 7;
  // Width of a vertex number on the ports.
  localparam int unsigned VtxW = 6;
  // Padded widths of the stream data buses.
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 8;

  typedef enum logic [1:0] {
    RD_SEL_A,
    RD_SEL_B,
    RD_SEL_K
  } rd_sel_e;

  typedef enum logic {
    WR_SEL_A,
    WR_SEL_B
  } wr_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    load_nbrs;
    logic    scan_step;
    logic    finish_acc;
    logic    emit_step;
  } thnq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_query;
    logic item_ok;
    logic scan_last;
    logic out_free;
    logic emit_fin;
  } thnq_stat_t;

endpackage

@@ sv/thnq_ram.sv @@
module thnq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read-first: a read of the address being written returns the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/thnq_ctrl.sv @@
module thnq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  thnq_pkg::thnq_stat_t stat_i,
  output thnq_pkg::thnq_cmd_t  cmd_o
);

  import thnq_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_E_RDA,
    ST_E_WRA,
    ST_E_WRB,
    ST_Q_RDA,
    ST_Q_NB,
    ST_Q_SCAN,
    ST_Q_DRAIN,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.rd_sel    = RD_SEL_K;
    cmd_o.wr_sel    = WR_SEL_A;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          if (!stat_i.is_query) begin
            state_d = stat_i.item_ok ? ST_E_RDA : ST_IDLE;
          end else begin
            state_d = stat_i.item_ok ? ST_Q_RDA : ST_EMIT;
          end
        end
      end
      ST_E_RDA: begin
        cmd_o.rd_sel = RD_SEL_A;
        state_d      = ST_E_WRA;
      end
      ST_E_WRA: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_SEL_A;
        cmd_o.rd_sel = RD_SEL_B;
        state_d      = ST_E_WRB;
      end
      ST_E_WRB: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_SEL_B;
        state_d      = ST_IDLE;
      end
      ST_Q_RDA: begin
        cmd_o.rd_sel = RD_SEL_A;
        state_d      = ST_Q_NB;
      end
      ST_Q_NB: begin
        cmd_o.load_nbrs = 1'b1;
        state_d         = ST_Q_SCAN;
      end
      ST_Q_SCAN: begin
        cmd_o.rd_sel    = RD_SEL_K;
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) begin
          state_d = ST_Q_DRAIN;
        end
      end
      ST_Q_DRAIN: begin
        cmd_o.finish_acc = 1'b1;
        state_d          = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit_step = 1'b1;
          if (stat_i.emit_fin) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

@@ sv/thnq_dp.sv @@
module thnq_dp #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [thnq_pkg::LimW-1:0]     cfg_data_i,
  input  logic                          in_action_i,
  input  logic [thnq_pkg::InDataW-1:0]  in_data_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [thnq_pkg::OutDataW-1:0] out_data_o,
  output logic                          out_found_o,
  output logic                          out_last_o,
  input  thnq_pkg::thnq_cmd_t           cmd_i,
  output thnq_pkg::thnq_stat_t          stat_o
);

  import thnq_pkg::*;

  localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam logic [MAX_VERTICES-1:0] OneBit = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

  logic [LimW-1:0]         limit_q;
  logic [LimW-1:0]         lim_eff;
  logic [MAX_VERTICES-1:0] mask;

  logic [VtxW-1:0] in_a, in_b;
  logic [VtxW-1:0] a_q, b_q;
  logic [AW-1:0]   a_adr, b_adr;

  logic [MAX_VERTICES-1:0] vld_q;
  logic                    rd_vld_q;
  logic [MAX_VERTICES-1:0] ram_rdata, rd_row;
  logic [AW-1:0]           raddr, waddr;
  logic [MAX_VERTICES-1:0] wdata;
  logic [MAX_VERTICES-1:0] bit_a, bit_b;

  logic [MAX_VERTICES-1:0] nbrs_q, acc_q, acc_or;
  logic                    pend_q;
  logic [AW-1:0]           k_q, idx_q;
  logic                    acc_zero, acc_rest_zero;

  logic            o_valid_q, o_found_q, o_last_q;
  logic [VtxW-1:0] o_vertex_q;

  // Vertex limit register; values above the vertex count act as the count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimW'(64);
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  assign lim_eff = (limit_q > LimW'(MAX_VERTICES)) ? LimW'(MAX_VERTICES) : limit_q;

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      mask[i] = (LimW'(i) < lim_eff);
    end
  end

  assign in_a = in_data_i[VtxW-1:0];
  assign in_b = in_data_i[2*VtxW-1:VtxW];

  assign stat_o.is_query = in_action_i;
  assign stat_o.item_ok  = in_action_i ? (LimW'(in_a) < lim_eff)
                                       : ((LimW'(in_a) < lim_eff) && (LimW'(in_b) < lim_eff));

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      a_q <= in_a;
      b_q <= in_b;
    end
  end

  assign a_adr = a_q[AW-1:0];
  assign b_adr = b_q[AW-1:0];
  assign bit_a = OneBit << a_adr;
  assign bit_b = OneBit << b_adr;

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_SEL_A: raddr = a_adr;
      RD_SEL_B: raddr = b_adr;
      RD_SEL_K: raddr = k_q;
      default:  raddr = k_q;
    endcase
  end

  assign waddr = (cmd_i.wr_sel == WR_SEL_A) ? a_adr : b_adr;
  assign wdata = rd_row | ((cmd_i.wr_sel == WR_SEL_A) ? bit_b : bit_a);

  thnq_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // Rows never written read as empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[raddr];
      if (cmd_i.wr_en) begin
        vld_q[waddr] <= 1'b1;
      end
    end
  end

  assign rd_row = rd_vld_q ? ram_rdata : '0;

  assign acc_or        = acc_q | (pend_q ? rd_row : '0);
  assign acc_zero      = (acc_q == '0);
  assign acc_rest_zero = (acc_q[MAX_VERTICES-1:1] == '0);

  assign stat_o.scan_last = ((LimW'(k_q) + LimW'(1)) == lim_eff);
  assign stat_o.emit_fin  = acc_zero || (acc_q[0] && acc_rest_zero);
  assign stat_o.out_free  = !o_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (cmd_i.accept || cmd_i.load_nbrs) begin
      pend_q <= 1'b0;
    end else if (cmd_i.scan_step) begin
      pend_q <= nbrs_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      acc_q <= '0;
    end else if (cmd_i.scan_step) begin
      acc_q <= acc_or;
    end else if (cmd_i.finish_acc) begin
      acc_q <= acc_or & mask & ~bit_a;
    end else if (cmd_i.emit_step) begin
      acc_q <= acc_q >> 1;
    end

    if (cmd_i.load_nbrs) begin
      nbrs_q <= rd_row & mask;
      k_q    <= '0;
    end else if (cmd_i.scan_step) begin
      nbrs_q <= nbrs_q >> 1;
      k_q    <= k_q + AW'(1);
    end

    if (cmd_i.accept) begin
      idx_q <= '0;
    end else if (cmd_i.emit_step) begin
      idx_q <= idx_q + AW'(1);
    end
  end

  // Output register: one result waits here while the next item is taken in.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (cmd_i.emit_step && (acc_zero || acc_q[0])) begin
      o_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_step) begin
      if (acc_zero) begin
        o_vertex_q <= '0;
        o_found_q  <= 1'b0;
        o_last_q   <= 1'b1;
      end else if (acc_q[0]) begin
        o_vertex_q <= VtxW'(idx_q);
        o_found_q  <= 1'b1;
        o_last_q   <= acc_rest_zero;
      end
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_data_o  = OutDataW'(o_vertex_q);
  assign out_found_o = o_found_q;
  assign out_last_o  = o_last_q;

endmodule

@@ sv/two_hop_neighbor_query_core.sv @@
// Two-hop neighbour query core. The block stores an undirected graph of up to
// MAX_VERTICES vertices as one adjacency row per vertex in a single-port-read
// RAM; reset leaves the graph empty. An input transaction with tuser low adds
// the edge between the two vertices in tdata (both endpoints must lie below
// the vertex limit, otherwise the transaction is dropped); it does one row
// read-modify-write for each endpoint. A transaction with tuser high queries
// the first vertex: the core reads that vertex's row, then reads one row per
// vertex below the limit, one per cycle on the RAM read port, ORing in the
// rows of the neighbours, removes the queried vertex and emits every
// remaining vertex in ascending order, one result per cycle at most and
// none while the receiver stalls, with tlast on the final one. An empty
// answer is a single transaction with tuser (found) low and tlast high. A
// query of a vertex outside the limit goes straight to that empty answer.
// The core handles one input transaction at a time, and a finished result
// waits in the output register while the next transaction is taken.
// Lowering the limit hides vertices at or above it without erasing their
// edges.
// The configuration channel is always ready and should only be written while
// the core is idle.
module two_hop_neighbor_query_core #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration write channel: vertex limit.
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [6:0] cfg_data_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [5:0] first_vertex, [11:6] second_vertex
  input  logic        s_axis_tuser,  // [0] action: 0 add edge, 1 query
  // Result stream.
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [5:0] neighbor_vertex
  output logic       m_axis_tuser,   // [0] found
  output logic       m_axis_tlast
);

  import thnq_pkg::*;

  `include "assert_macros.svh"

  thnq_cmd_t  cmd;
  thnq_stat_t stat;

  // Configuration writes need no back-pressure: the register updates at once.
  assign cfg_ready_o = 1'b1;

  thnq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  thnq_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_action_i (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_found_o (m_axis_tuser),
    .out_last_o  (m_axis_tlast),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

  // A new transaction is never taken while results are being produced.
  `ASSERT_SAME(a_no_accept_in_emit, clk_i, rst_ni, s_axis_tready, !cmd.emit_step)
  // The adjacency RAM is never written in the cycle an item is accepted.
  `ASSERT_SAME(a_no_write_on_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !cmd.wr_en)
  // A result is only produced when the output register can take it.
  `ASSERT_SAME(a_emit_when_free, clk_i, rst_ni, cmd.emit_step, stat.out_free)
  // An empty answer is always the final result of its query.
  `ASSERT_SAME(a_empty_is_last, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser, m_axis_tlast)

endmodule

@@ tb/two_hop_neighbor_query_core_tb.sv @@
module two_hop_neighbor_query_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import thnq_pkg::*;

  // Operation codes carried in the input tuser bit.
  localparam logic ACT_ADD_EDGE = 1'b0;
  localparam logic ACT_QUERY    = 1'b1;

  localparam int unsigned NUM_VERTICES = 64;
  // A query scans one row per vertex below the limit and may then walk every
  // vertex position once more while emitting, so a settled core is reached
  // well before this wait runs out once the last result has left.
  localparam int unsigned SETTLE_CYCLES = 80;
  // The slowest correct run (every query giving 63 results, each held up by the
  // longest stall) stays far below this.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // One result transaction as the core should present it.
  typedef struct packed {
    logic [VtxW-1:0] vertex;
    logic            found;
    logic            last;
  } answer_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [LimW-1:0]     cfg_data_i  = '0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;   // [5:0] first_vertex, [11:6] second_vertex
  logic                s_axis_tuser  = 1'b0; // [0] action

  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;         // [5:0] neighbor_vertex
  logic                m_axis_tuser;         // [0] found
  logic                m_axis_tlast;

  // Shadow of the graph and of the limit register, kept in step with the core.
  logic [NUM_VERTICES-1:0] adj_rows [NUM_VERTICES];
  logic [LimW-1:0]         vertex_limit;

  // Results still owed by the core, oldest first.
  answer_t answer_q [$];

  // Idling controls: both sides stop idling for the closing part of the run.
  bit bursts_on = 1'b1;
  bit stalls_on = 1'b1;
  int stall_left = 0;

  int unsigned cycle_count    = 0;
  int unsigned fail_count     = 0;
  int unsigned items_sent     = 0;
  int unsigned queries_sent   = 0;
  int unsigned results_seen   = 0;
  int unsigned limits_written = 0;

  two_hop_neighbor_query_core #(
    .MAX_VERTICES(NUM_VERTICES)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake must not leave the run spinning for ever.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles without finishing.", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result-side back-pressure. A stall holds tready low for a burst; between
  // bursts the receiver is always ready.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stalls_on && rst_ni && $urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(1, 5) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Result checking. Outputs only change on the rising edge, so the values
  // seen at the falling edge are exactly those that the next rising edge will
  // transfer when valid and ready are both high.
  always @(negedge clk_i) begin
    answer_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen <= results_seen + 1;
      if (answer_q.size() == 0) begin
        $error("Unexpected result transaction: neighbor_vertex %0d found %0b last %0b",
               m_axis_tdata[VtxW-1:0], m_axis_tuser, m_axis_tlast);
        fail_count++;
      end else begin
        want = answer_q.pop_front();
        if (m_axis_tdata[VtxW-1:0] !== want.vertex) begin
          $error("neighbor_vertex: expected %0d, got %0d", want.vertex,
                 m_axis_tdata[VtxW-1:0]);
          fail_count++;
        end
        if (m_axis_tuser !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  // Adds one result to the back of the list of owed results.
  function automatic void queue_answer(input answer_t ans);
    answer_q.insert(answer_q.size(), ans);
  endfunction

  // Applies one accepted transaction to the shadow graph and queues the
  // answer that a query produces. Vertices at or above the limit are invisible,
  // but bits already stored for them are kept for when the limit rises again.
  function automatic void predict_answers(input logic act, input logic [VtxW-1:0] first_v,
                                          input logic [VtxW-1:0] second_v);
    int unsigned             lim;
    logic [NUM_VERTICES-1:0] in_use;
    logic [NUM_VERTICES-1:0] nbrs;
    logic [NUM_VERTICES-1:0] reach;
    answer_t                 ans;
    lim    = (vertex_limit > NUM_VERTICES) ? NUM_VERTICES : vertex_limit;
    in_use = (lim >= NUM_VERTICES) ? '1 : ((64'd1 << lim) - 64'd1);
    if (act == ACT_ADD_EDGE) begin
      if (first_v < lim && second_v < lim) begin
        adj_rows[first_v][second_v] = 1'b1;
        adj_rows[second_v][first_v] = 1'b1;
      end
      return;
    end
    reach = '0;
    if (first_v < lim) begin
      nbrs = adj_rows[first_v] & in_use;
      for (int k = 0; k < NUM_VERTICES; k++) begin
        if (nbrs[k]) begin
          reach |= adj_rows[k];
        end
      end
      reach &= in_use;
      reach[first_v] = 1'b0;
    end
    if (reach == '0) begin
      ans = '{vertex: '0, found: 1'b0, last: 1'b1};
      queue_answer(ans);
      return;
    end
    for (int k = 0; k < NUM_VERTICES; k++) begin
      if (reach[k]) begin
        ans.vertex = k[VtxW-1:0];
        ans.found  = 1'b1;
        // The final vertex of the answer is the one with nothing set above it.
        ans.last   = ((reach >> (k + 1)) == '0);
        queue_answer(ans);
      end
    end
  endfunction

  // Sends one item on the input stream, with an occasional idle burst first,
  // and records its effect once the core has accepted it. Every task here
  // returns just after a rising edge.
  task automatic send_item(input logic act, input logic [VtxW-1:0] first_v,
                           input logic [VtxW-1:0] second_v);
    bit taken;
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW - 2 * VtxW){1'b0}}, second_v, first_v};
    s_axis_tuser  <= act;
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
    predict_answers(act, first_v, second_v);
    items_sent++;
    if (act == ACT_QUERY) begin
      queries_sent++;
    end
  endtask

  // Holds the input stream idle until every owed result has come out. It
  // always waits on the clock first, so the caller may drive the stream again at once.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (answer_q.size() != 0);
  endtask

  // An add-edge gives no result, so the core may still be writing its rows
  // after the last result has gone; allow it to finish before touching the
  // register.
  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LimW-1:0] value);
    bit taken;
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    cfg_valid_i  <= 1'b0;
    vertex_limit = value;
    limits_written++;
  endtask

  // An empty graph answers every query with the single not-found transaction.
  task automatic test_empty_graph();
    send_item(ACT_QUERY, 6'd0, 6'd0);
    send_item(ACT_QUERY, 6'd63, 6'd63);
  endtask

  // Edges at both ends of the vertex range, a self loop and a duplicate edge,
  // then queries whose answers are single vertices and, for the self loop, empty.
  task automatic test_edges_and_queries();
    send_item(ACT_ADD_EDGE, 6'd0, 6'd63);
    send_item(ACT_ADD_EDGE, 6'd63, 6'd1);
    send_item(ACT_ADD_EDGE, 6'd1, 6'd2);
    send_item(ACT_ADD_EDGE, 6'd5, 6'd5);
    send_item(ACT_ADD_EDGE, 6'd0, 6'd63);
    send_item(ACT_QUERY, 6'd0, 6'd63);
    send_item(ACT_QUERY, 6'd63, 6'd0);
    send_item(ACT_QUERY, 6'd5, 6'd0);
    send_item(ACT_QUERY, 6'd1, 6'd0);
  endtask

  // Lowering the limit hides stored edges, drops edges on vertices beyond it and
  // answers queries on them as empty; raising it again brings the hidden edges back.
  task automatic test_limit_masking();
    write_limit(7'd2);
    send_item(ACT_QUERY, 6'd1, 6'd0);
    send_item(ACT_ADD_EDGE, 6'd0, 6'd2);
    send_item(ACT_ADD_EDGE, 6'd0, 6'd1);
    send_item(ACT_ADD_EDGE, 6'd63, 6'd62);
    send_item(ACT_QUERY, 6'd0, 6'd0);
    send_item(ACT_QUERY, 6'd63, 6'd0);
    write_limit(7'd1);
    send_item(ACT_ADD_EDGE, 6'd0, 6'd0);
    send_item(ACT_QUERY, 6'd0, 6'd0);
    send_item(ACT_QUERY, 6'd1, 6'd0);
    write_limit(7'd64);
    send_item(ACT_QUERY, 6'd0, 6'd0);
  endtask

  // Mostly well-formed edges and queries inside the current limit so that the
  // graph fills up and answers grow long, with some items on arbitrary
  // vertices mixed in as noise.
  task automatic send_random_item();
    int unsigned     roll;
    int unsigned     top;
    logic [VtxW-1:0] first_v;
    logic [VtxW-1:0] second_v;
    roll = $urandom_range(0, 99);
    top  = ((vertex_limit > NUM_VERTICES) ? NUM_VERTICES : vertex_limit) - 1;
    if (roll < 55) begin
      first_v  = VtxW'($urandom_range(0, top));
      second_v = VtxW'($urandom_range(0, top));
      send_item(ACT_ADD_EDGE, first_v, second_v);
    end else if (roll < 85) begin
      first_v  = VtxW'($urandom_range(0, top));
      second_v = VtxW'($urandom_range(0, NUM_VERTICES - 1));
      send_item(ACT_QUERY, first_v, second_v);
    end else begin
      first_v  = VtxW'($urandom_range(0, NUM_VERTICES - 1));
      second_v = VtxW'($urandom_range(0, NUM_VERTICES - 1));
      send_item(logic'($urandom_range(0, 1)), first_v, second_v);
    end
  endtask

  task automatic run_random_phase(input logic [LimW-1:0] limit, input int unsigned count);
    write_limit(limit);
    for (int unsigned n = 0; n < count; n++) begin
      send_random_item();
    end
  endtask

  task automatic test_random_limits();
    run_random_phase(7'd64, 80);
    run_random_phase(7'($urandom_range(1, 64)), 50);
    run_random_phase(7'd8, 50);
    write_limit(7'd63);
    for (int unsigned n = 0; n < 40; n++) begin
      // Halfway through, the sender waits for every owed result to come out
      // before carrying on.
      if (n == 20) begin
        wait_drained();
      end
      send_random_item();
    end
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_full_rate();
    bursts_on = 1'b0;
    stalls_on = 1'b0;
    run_random_phase(7'd64, 60);
  endtask

  initial begin
    for (int k = 0; k < NUM_VERTICES; k++) begin
      adj_rows[k] = '0;
    end
    vertex_limit = 7'd64;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_graph();
    test_edges_and_queries();
    test_limit_masking();
    test_random_limits();
    test_full_rate();
    wait_idle();

    $display("Sent %0d input transactions (%0d queries) under %0d limit settings.",
             items_sent, queries_sent, limits_written);
    $display("Checked %0d result transactions; %0d mismatches.", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ two_hop_neighbor_query_core.f @@
+incdir+sv
sv/thnq_pkg.sv
sv/thnq_ram.sv
sv/thnq_ctrl.sv
sv/thnq_dp.sv
sv/two_hop_neighbor_query_core.sv
tb/two_hop_neighbor_query_core_tb.sv
